// ===== hw/rtl/igdm_pkg.sv =====
// ----------------------------------------------------------------------------
// igdm_pkg
// Shared types, widths and codes for the greedy IoU detection matcher.
// ----------------------------------------------------------------------------
package igdm_pkg;

  // Table size and coordinate width
  localparam int MAX_TRUTHS  = 16;
  localparam int COORD_BITS  = 12;

  // Derived widths
  localparam int SLOT_W  = (MAX_TRUTHS > 1) ? $clog2(MAX_TRUTHS) : 1;
  localparam int CNT_W   = $clog2(MAX_TRUTHS + 1);
  localparam int GATE_W  = COORD_BITS + 3;
  localparam int SPAN_W  = COORD_BITS + 3;
  localparam int AREA_W  = 2 * COORD_BITS;
  localparam int SUM_W   = 2 * COORD_BITS + 1;
  localparam int IA_W    = 2 * COORD_BITS + 2;
  localparam int UA_W    = 2 * COORD_BITS + 3;
  localparam int THR_W   = 9;
  localparam int PROD_W  = IA_W + THR_W;

  // Fixed result field widths
  localparam int IDX_W   = 4;
  localparam int FN_W    = 5;
  localparam int TALLY_W = 16;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(205);

  // Item operation codes
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_SCORE = 2'd1,
    OP_END   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // One rectangle
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
  } rect_t;

  // One table entry as it travels around the ring
  typedef struct packed {
    logic  valid;
    rect_t rect;
  } entry_t;

  // Scorer verdict for one slot
  typedef struct packed {
    logic              vld;
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } score_t;

endpackage

// ===== hw/rtl/igdm_cell.sv =====
// ----------------------------------------------------------------------------
// igdm_cell
// One truth table slot. Holds a rectangle and its valid bit and passes them
// to the next cell of the ring while a scan rotates the table.
// ----------------------------------------------------------------------------
module igdm_cell
  import igdm_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   shift,
  input  logic   load,
  input  logic   clear,
  input  logic   flush,
  input  rect_t  load_rect,
  input  entry_t nbr,
  output entry_t ent
);

  logic  ent_valid;
  rect_t ent_rect;

  // Valid bit: flush at end of frame, set on load, drop on match, advance on shift
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
    end else if (flush) begin
      ent_valid <= 1'b0;
    end else if (load) begin
      ent_valid <= 1'b1;
    end else if (clear) begin
      ent_valid <= 1'b0;
    end else if (shift) begin
      ent_valid <= nbr.valid;
    end
  end

  // Rectangle payload: write on load, advance on shift
  always_ff @(posedge clk) begin
    if (load) begin
      ent_rect <= load_rect;
    end else if (shift) begin
      ent_rect <= nbr.rect;
    end
  end

  assign ent = '{valid: ent_valid, rect: ent_rect};

endmodule

// ===== hw/rtl/igdm_scorer.sv =====
// ----------------------------------------------------------------------------
// igdm_scorer
// Four-stage pipeline that scores the head entry of the ring against the
// held prediction: size gate and intersection sides, areas, union, and the
// thresholded overlap compare. One slot enters per cycle.
// ----------------------------------------------------------------------------
module igdm_scorer
  import igdm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              pred_load,
  input  rect_t             pred_in,
  input  logic              issue,
  input  logic [SLOT_W-1:0] issue_slot,
  input  entry_t            head,
  input  logic [THR_W-1:0]  thr,
  output score_t            verdict
);

  rect_t                  pred;
  logic [AREA_W-1:0]      pred_area;

  // Stage 1 combinational
  logic [GATE_W-1:0]      p5w, p5h, t6w, t6h;
  logic [COORD_BITS:0]    t_r, t_b, p_r, p_b, r_min, b_min;
  logic [COORD_BITS-1:0]  l_max, u_max;
  logic signed [SPAN_W-1:0] iw, ih;
  logic                   gate_ok, span_ok;
  logic [AREA_W-1:0]      t_area;

  // Stage registers
  logic                   s1_vld, s1_ok;
  logic [SLOT_W-1:0]      s1_slot;
  logic [COORD_BITS:0]    s1_iw, s1_ih;
  logic [AREA_W-1:0]      s1_ta;

  logic                   s2_vld, s2_ok;
  logic [SLOT_W-1:0]      s2_slot;
  logic [IA_W-1:0]        s2_ia;
  logic [SUM_W-1:0]       s2_sum;

  logic                   s3_vld, s3_ok;
  logic [SLOT_W-1:0]      s3_slot;
  logic [IA_W-1:0]        s3_ia;
  logic signed [UA_W-1:0] s3_ua;

  logic                   v_vld, v_hit;
  logic [SLOT_W-1:0]      v_slot;

  logic [IA_W-1:0]        ia_mul;
  logic [PROD_W-1:0]      lhs, rhs;
  logic                   ua_zero, ua_neg, hit;

  // Hold the prediction and its area for the whole scan
  always_ff @(posedge clk) begin
    if (pred_load) begin
      pred      <= pred_in;
      pred_area <= pred_in.w * pred_in.h;
    end
  end

  // Stage 1: size gate, intersection sides, truth area
  always_comb begin
    p5w    = GATE_W'({pred.w, 2'b00}) + GATE_W'(pred.w);
    p5h    = GATE_W'({pred.h, 2'b00}) + GATE_W'(pred.h);
    t6w    = GATE_W'({head.rect.w, 2'b00}) + GATE_W'({head.rect.w, 1'b0});
    t6h    = GATE_W'({head.rect.h, 2'b00}) + GATE_W'({head.rect.h, 1'b0});
    gate_ok = !(p5h > t6h) && !(p5w > t6w);

    t_r   = {1'b0, head.rect.x} + {1'b0, head.rect.w};
    t_b   = {1'b0, head.rect.y} + {1'b0, head.rect.h};
    p_r   = {1'b0, pred.x} + {1'b0, pred.w};
    p_b   = {1'b0, pred.y} + {1'b0, pred.h};
    r_min = (t_r < p_r) ? t_r : p_r;
    b_min = (t_b < p_b) ? t_b : p_b;
    l_max = (head.rect.x > pred.x) ? head.rect.x : pred.x;
    u_max = (head.rect.y > pred.y) ? head.rect.y : pred.y;

    iw = $signed({2'b00, r_min}) - $signed({3'b000, l_max}) + $signed(SPAN_W'(1));
    ih = $signed({2'b00, b_min}) - $signed({3'b000, u_max}) + $signed(SPAN_W'(1));
    span_ok = !iw[SPAN_W-1] && (iw != '0) && !ih[SPAN_W-1] && (ih != '0);

    t_area = head.rect.w * head.rect.h;
  end

  // Stage 2 intersection area and stage 4 overlap compare, combinational
  always_comb begin
    ia_mul  = s1_iw * s1_ih;
    ua_zero = (s3_ua == '0);
    ua_neg  = s3_ua[UA_W-1];
    lhs     = PROD_W'({s3_ia, 8'b0000_0000});
    rhs     = thr * s3_ua[UA_W-2:0];
    hit     = s3_ok && (ua_zero || (!ua_neg && (lhs > rhs)));
  end

  // Advance the pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      v_vld  <= 1'b0;
    end else begin
      s1_vld <= issue;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      v_vld  <= s3_vld;
    end
  end

  // Advance the pipeline payload
  always_ff @(posedge clk) begin
    s1_ok   <= head.valid && gate_ok && span_ok;
    s1_slot <= issue_slot;
    s1_iw   <= iw[COORD_BITS:0];
    s1_ih   <= ih[COORD_BITS:0];
    s1_ta   <= t_area;

    s2_ok   <= s1_ok;
    s2_slot <= s1_slot;
    s2_ia   <= ia_mul;
    s2_sum  <= SUM_W'(s1_ta) + SUM_W'(pred_area);

    s3_ok   <= s2_ok;
    s3_slot <= s2_slot;
    s3_ia   <= s2_ia;
    s3_ua   <= $signed({2'b00, s2_sum}) - $signed({1'b0, s2_ia});

    v_hit   <= hit;
    v_slot  <= s3_slot;
  end

  assign verdict = '{vld: v_vld, hit: v_hit, slot: v_slot};

endmodule

// ===== hw/rtl/iou_greedy_detection_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// iou_greedy_detection_matcher_unit
// Greedy IoU matcher of predicted rectangles against a frame's truth table.
//
// Usage: an item is taken when start is high and busy is low. operation
// selects load truth, score prediction or end frame. Every item gives one
// result on the result ports, marked by result_valid for one cycle.
// Loads, end-frame and unused codes are reported the cycle after acceptance
// and busy stays low, so one of them can be taken every cycle.
// A prediction rotates the ring of table cells once past a four-stage
// scoring pipeline: busy is high for the whole scan and result_valid is
// high in the cycle busy falls. The ring rotation and the scorer pipeline
// depth set how long one prediction takes; no new item is taken while busy.
// The overlap threshold is written through cfg_write / cfg_data while the
// block is idle. Reset clears the table valid bits, all counts and the
// threshold (back to 205/256); it needs no clearing pass. Results cannot
// be held off by the receiver: each is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module iou_greedy_detection_matcher_unit
  import igdm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            operation,
  input  logic [COORD_BITS-1:0] rect_x,
  input  logic [COORD_BITS-1:0] rect_y,
  input  logic [COORD_BITS-1:0] rect_width,
  input  logic [COORD_BITS-1:0] rect_height,
  input  logic                  cfg_write,
  input  logic [THR_W-1:0]      cfg_data,
  output logic                  result_valid,
  output logic                  matched,
  output logic [IDX_W-1:0]      match_index,
  output logic [TALLY_W-1:0]    true_positives,
  output logic [TALLY_W-1:0]    false_positives,
  output logic [FN_W-1:0]       false_negatives,
  output logic                  table_overflow,
  output logic                  frame_done
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    step;
  logic                found;
  logic [SLOT_W-1:0]   found_idx;

  logic [THR_W-1:0]    thr;
  logic [CNT_W-1:0]    load_count;
  logic [CNT_W-1:0]    live_count;
  logic [TALLY_W-1:0]  hit_count;
  logic [TALLY_W-1:0]  miss_count;
  logic                overflow_seen;

  op_t                 op_in;
  rect_t               rect_in;
  logic                accept, full, shift, fin, fin_found, do_load, do_flush;
  logic [SLOT_W-1:0]   fin_idx;
  logic [TALLY_W-1:0]  hit_inc, miss_inc;

  entry_t              ent   [MAX_TRUTHS];
  logic                load_en [MAX_TRUTHS];
  logic                clr_en  [MAX_TRUTHS];
  score_t              verdict;

  // Decode the incoming item and the scan progress
  always_comb begin
    op_in     = op_t'(operation);
    rect_in   = '{x: rect_x, y: rect_y, w: rect_width, h: rect_height};
    busy      = (state != ST_IDLE);
    accept    = start && !busy;
    full      = (load_count >= CNT_W'(MAX_TRUTHS));
    do_load   = accept && (op_in == OP_LOAD) && !full;
    do_flush  = accept && (op_in == OP_END);
    shift     = (state == ST_SCAN) && (step < CNT_W'(MAX_TRUTHS));
    fin       = (state == ST_SCAN) && verdict.vld &&
                (verdict.slot == SLOT_W'(MAX_TRUTHS - 1));
    fin_found = found || (verdict.vld && verdict.hit);
    fin_idx   = found ? found_idx : verdict.slot;
    hit_inc   = (hit_count != '1) ? hit_count + 1'b1 : hit_count;
    miss_inc  = (miss_count != '1) ? miss_count + 1'b1 : miss_count;
  end

  // Ring of table cells; cell 0 is the head seen by the scorer
  for (genvar i = 0; i < MAX_TRUTHS; i++) begin : g_cell
    assign load_en[i] = do_load && (load_count == CNT_W'(i));
    assign clr_en[i]  = fin && fin_found && (fin_idx == SLOT_W'(i));

    igdm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (shift),
      .load      (load_en[i]),
      .clear     (clr_en[i]),
      .flush     (do_flush),
      .load_rect (rect_in),
      .nbr       (ent[(i + 1) % MAX_TRUTHS]),
      .ent       (ent[i])
    );
  end

  igdm_scorer u_scorer (
    .clk        (clk),
    .rst        (rst),
    .pred_load  (accept && (op_in == OP_SCORE)),
    .pred_in    (rect_in),
    .issue      (shift),
    .issue_slot (step[SLOT_W-1:0]),
    .head       (ent[0]),
    .thr        (thr),
    .verdict    (verdict)
  );

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_write) begin
      thr <= cfg_data;
    end
  end

  // Sequencer, frame counts and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= '0;
      found         <= 1'b0;
      found_idx     <= '0;
      load_count    <= '0;
      live_count    <= '0;
      hit_count     <= '0;
      miss_count    <= '0;
      overflow_seen <= 1'b0;
      result_valid  <= 1'b0;
      matched       <= 1'b0;
      match_index   <= '0;
      true_positives  <= '0;
      false_positives <= '0;
      false_negatives <= '0;
      table_overflow  <= 1'b0;
      frame_done      <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            matched         <= 1'b0;
            match_index     <= '0;
            frame_done      <= 1'b0;
            true_positives  <= hit_count;
            false_positives <= miss_count;
            false_negatives <= FN_W'(live_count);
            table_overflow  <= overflow_seen;
            unique case (op_in)
              OP_LOAD: begin
                result_valid <= 1'b1;
                if (!full) begin
                  load_count      <= load_count + 1'b1;
                  live_count      <= live_count + 1'b1;
                  false_negatives <= FN_W'(live_count + 1'b1);
                end else begin
                  overflow_seen  <= 1'b1;
                  table_overflow <= 1'b1;
                end
              end
              OP_SCORE: begin
                state     <= ST_SCAN;
                step      <= '0;
                found     <= 1'b0;
                found_idx <= '0;
              end
              OP_END: begin
                result_valid  <= 1'b1;
                frame_done    <= 1'b1;
                load_count    <= '0;
                live_count    <= '0;
                hit_count     <= '0;
                miss_count    <= '0;
                overflow_seen <= 1'b0;
              end
              OP_NONE: begin
                result_valid <= 1'b1;
              end
              default: begin
                result_valid <= 1'b1;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (shift) begin
            step <= step + 1'b1;
          end
          // Keep the first hit in slot order
          if (verdict.vld && verdict.hit && !found) begin
            found     <= 1'b1;
            found_idx <= verdict.slot;
          end
          if (fin) begin
            state           <= ST_IDLE;
            result_valid    <= 1'b1;
            matched         <= fin_found;
            frame_done      <= 1'b0;
            table_overflow  <= overflow_seen;
            if (fin_found) begin
              match_index     <= IDX_W'(fin_idx);
              hit_count       <= hit_inc;
              live_count      <= live_count - 1'b1;
              true_positives  <= hit_inc;
              false_positives <= miss_count;
              false_negatives <= FN_W'(live_count - 1'b1);
            end else begin
              match_index     <= '0;
              miss_count      <= miss_inc;
              true_positives  <= hit_count;
              false_positives <= miss_inc;
              false_negatives <= FN_W'(live_count);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_live_le_load: assert property (@(posedge clk) disable iff (rst)
    live_count <= load_count)
    else $error("live entry count exceeds loaded count");

  a_load_le_max: assert property (@(posedge clk) disable iff (rst)
    load_count <= CNT_W'(MAX_TRUTHS))
    else $error("load count beyond table size");

  a_scan_reports: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> result_valid)
    else $error("scan ended without a result");

  a_frame_clears: assert property (@(posedge clk) disable iff (rst)
    (result_valid && frame_done) |-> (load_count == '0 && live_count == '0 &&
                                      hit_count == '0 && miss_count == '0))
    else $error("frame end left counts behind");

  a_match_not_frame: assert property (@(posedge clk) disable iff (rst)
    (result_valid && matched) |-> ($past(busy) && !frame_done))
    else $error("match reported outside a scan");
`endif

endmodule
